/* hw/rtl/glg_pkg.sv */
// Package with types, constants and lookup tables for the GAN loss and gradient block.
`default_nettype none

package glg_pkg;

    typedef enum logic [2:0] {
        MODE_BCE_REAL  = 3'd0,
        MODE_BCE_FAKE  = 3'd1,
        MODE_HINGE_DR  = 3'd2,
        MODE_HINGE_DF  = 3'd3,
        MODE_HINGE_G   = 3'd4
    } loss_mode_t;

    // register index, taken from paddr[2]
    localparam logic REG_LOSS_MODE     = 1'b0;
    localparam logic REG_ELEMENT_COUNT = 1'b1;

    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    localparam logic [25:0] BCE_CAP_Q16 = 26'd1810827;
    localparam logic [24:0] ONE_Q16     = 25'd65536;
    localparam logic [16:0] MAX_COUNT   = 17'd65536;
    localparam logic [15:0] LN2_Q16     = 16'd45426;

    // 2^-(i/16) in Q16
    function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // ln(1 + i/16) in Q16
    function automatic logic [15:0] ln1p_tab(input logic [4:0] idx);
        logic [15:0] v;
        case (idx)
            5'd0:    v = 16'd0;
            5'd1:    v = 16'd3973;
            5'd2:    v = 16'd7719;
            5'd3:    v = 16'd11262;
            5'd4:    v = 16'd14624;
            5'd5:    v = 16'd17821;
            5'd6:    v = 16'd20870;
            5'd7:    v = 16'd23783;
            5'd8:    v = 16'd26573;
            5'd9:    v = 16'd29248;
            5'd10:   v = 16'd31818;
            5'd11:   v = 16'd34292;
            5'd12:   v = 16'd36675;
            5'd13:   v = 16'd38975;
            5'd14:   v = 16'd41196;
            5'd15:   v = 16'd43345;
            default: v = 16'd45426;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/gan_loss_and_gradient.sv */
// Top level of the GAN loss and gradient block: sequencer, shared divider and APB registers.
`default_nettype none

// One logit (Q8.8) enters per transaction and one result leaves: the logit's
// gradient divided by the element count (Q2.30) and, on the transaction marked
// tlast, the batch mean loss (Q16.16, zero otherwise). loss_mode picks BCE
// real/fake or hinge discriminator real/fake/generator; element_count is the
// batch size, with 0 read as 1 and anything above 65536 read as 65536. A
// single restoring divider, one quotient bit per cycle, carries the sigmoid,
// the gradient scaling and the mean. A BCE item is accepted, set up, then goes
// through exp, log, the sigmoid division, the gradient division, the sum and
// the output; hinge items skip exp, log and the sigmoid, and a tlast item adds
// the mean division after the sum. s_tready is high only while the sequencer
// is idle; the output register lets the next transaction enter while a result
// waits.
// Write registers only between batches with no transaction in flight.
module gan_loss_and_gradient (
    input  wire         aclk,
    input  wire         aresetn,
    // input stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // [15:0] logit
    input  wire         s_tlast,
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,   // [31:0] grad, [63:32] mean_loss
    output logic        m_tlast,
    // configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import glg_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL  = 9'b000000010,
        S_EXP  = 9'b000000100,
        S_LN   = 9'b000001000,
        S_DIVP = 9'b000010000,
        S_DIVG = 9'b000100000,
        S_SUM  = 9'b001000000,
        S_DIVM = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

    state_t             state_reg;
    logic [2:0]         loss_mode_reg;
    logic [16:0]        element_count_reg;

    logic signed [23:0] x16_reg;
    logic               last_reg;
    logic [2:0]         mode_reg;
    logic [16:0]        n_reg;
    logic [24:0]        u_reg;
    logic [32:0]        e_reg;
    logic signed [25:0] term_reg;
    logic               neg_reg;
    logic [31:0]        grad_reg;
    logic [31:0]        mean_reg;
    logic signed [39:0] loss_sum_reg;

    // shared divider
    logic [62:0]        dvd_reg;
    logic [34:0]        rem_reg;
    logic [62:0]        quo_reg;
    logic [33:0]        dsr_reg;
    logic [5:0]         cnt_reg;

    logic               m_tvalid_reg;
    logic [31:0]        m_grad_reg;
    logic [31:0]        m_mean_reg;
    logic               m_last_reg;

    // ---------------- configuration port ----------------
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb begin
        case (paddr[2])
            REG_LOSS_MODE: prdata = {29'd0, loss_mode_reg};
            default:       prdata = {15'd0, element_count_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_mode_reg     <= 3'd0;
            element_count_reg <= 17'd1;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOSS_MODE) begin
                loss_mode_reg <= pwdata[2:0];
            end else begin
                element_count_reg <= pwdata[16:0];
            end
        end
    end

    // ---------------- datapath ----------------
    logic [16:0] n_clamp;
    always_comb begin
        if (element_count_reg == 17'd0) begin
            n_clamp = 17'd1;
        end else if (element_count_reg > MAX_COUNT) begin
            n_clamp = MAX_COUNT;
        end else begin
            n_clamp = element_count_reg;
        end
    end

    logic [23:0] t_abs;
    logic [40:0] prod;
    assign t_abs = x16_reg[23] ? (~x16_reg + 24'd1) : x16_reg;
    assign prod  = {17'd0, t_abs} * {24'd0, LOG2E_Q16};

    // exp(-t) in Q32 from u = t*log2(e)
    logic [8:0]  k_val;
    logic [16:0] pa, pb, pdiff, mval;
    logic [23:0] pip;
    logic [32:0] e_val;
    always_comb begin
        k_val = u_reg[24:16];
        pa    = pow2_tab({1'b0, u_reg[15:12]});
        pb    = pow2_tab({1'b0, u_reg[15:12]} + 5'd1);
        pdiff = pa - pb;
        pip   = {12'd0, pdiff[11:0]} * {12'd0, u_reg[11:0]};
        mval  = pa - {5'd0, pip[23:12]};
        if (k_val >= 9'd48) begin
            e_val = 33'd0;
        end else begin
            e_val = {mval, 16'd0} >> k_val;
        end
    end

    // softplus term for BCE
    logic [15:0]        la, lb, ldiff, ln_val;
    logic [27:0]        lip;
    logic signed [24:0] sx, zs, zpos;
    logic signed [25:0] bterm;
    always_comb begin
        la    = ln1p_tab({1'b0, e_reg[31:28]});
        lb    = ln1p_tab({1'b0, e_reg[31:28]} + 5'd1);
        ldiff = lb - la;
        lip   = {16'd0, ldiff[11:0]} * {12'd0, e_reg[27:12]};
        ln_val = e_reg[32] ? LN2_Q16 : la + {4'd0, lip[27:16]};
        sx    = {x16_reg[23], x16_reg};
        zs    = (mode_reg == MODE_BCE_REAL) ? -sx : sx;
        zpos  = zs[24] ? 25'sd0 : zs;
        bterm = {zpos[24], zpos} + $signed({10'd0, ln_val});
        if (bterm > $signed(BCE_CAP_Q16)) begin
            bterm = $signed(BCE_CAP_Q16);
        end
    end

    // hinge margins
    logic signed [24:0] hm_real, hm_fake;
    assign hm_real = $signed(ONE_Q16) - sx;
    assign hm_fake = $signed(ONE_Q16) + sx;

    // hinge and unused modes: loss term, sign and gradient dividend from setup
    logic signed [25:0] h_term;
    logic               h_neg;
    logic [62:0]        h_dvd;
    always_comb begin
        h_term = 26'sd0;
        h_neg  = 1'b0;
        h_dvd  = 63'd0;
        case (mode_reg)
            MODE_HINGE_DR: begin
                if (hm_real > 25'sd0) begin
                    h_term = {hm_real[24], hm_real};
                    h_neg  = 1'b1;
                    h_dvd  = {31'h4000_0000, 32'd0};
                end
            end
            MODE_HINGE_DF: begin
                if (hm_fake > 25'sd0) begin
                    h_term = {hm_fake[24], hm_fake};
                    h_dvd  = {31'h4000_0000, 32'd0};
                end
            end
            MODE_HINGE_G: begin
                h_term = -{sx[24], sx};
                h_neg  = 1'b1;
                h_dvd  = {31'h4000_0000, 32'd0};
            end
            default: begin
            end
        endcase
    end

    // divider step
    logic [34:0] rs;
    logic        ge;
    logic [34:0] rem_next;
    logic [62:0] quo_next;
    assign rs       = {rem_reg[33:0], dvd_reg[62]};
    assign ge       = rs >= {1'b0, dsr_reg};
    assign rem_next = ge ? rs - {1'b0, dsr_reg} : rs;
    assign quo_next = {quo_reg[61:0], ge};

    logic div_done;
    assign div_done = (cnt_reg == 6'd1);

    // sigmoid-based gradient magnitude
    logic [30:0] p_val, bce_mag;
    assign p_val   = quo_next[30:0];
    assign bce_mag = (mode_reg == MODE_BCE_REAL) ? (31'h4000_0000 - p_val) : p_val;

    // saturating sum
    logic signed [40:0] sum_wide;
    logic signed [39:0] sum_sat;
    logic [39:0]        sum_mag;
    always_comb begin
        sum_wide = {loss_sum_reg[39], loss_sum_reg} + {{15{term_reg[25]}}, term_reg};
        if (sum_wide > 41'sh07F_FFFF_FFFF) begin
            sum_sat = 40'sh7F_FFFF_FFFF;
        end else if (sum_wide < -41'sh080_0000_0000) begin
            sum_sat = -40'sh80_0000_0000;
        end else begin
            sum_sat = sum_wide[39:0];
        end
        sum_mag = sum_sat[39] ? (~sum_sat + 40'd1) : sum_sat;
    end

    // mean with saturation to 32 bits
    logic [39:0] mq;
    logic [31:0] mean_sat;
    always_comb begin
        mq = quo_next[39:0];
        if (!neg_reg) begin
            mean_sat = (mq > 40'h00_7FFF_FFFF) ? 32'h7FFF_FFFF : mq[31:0];
        end else begin
            mean_sat = (mq > 40'h00_8000_0000) ? 32'h8000_0000 : (~mq[31:0] + 32'd1);
        end
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            loss_sum_reg <= 40'sd0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= 6'd0;
        end else begin
            // S_DONE reloads the output register itself
            if (m_tvalid_reg && m_tready && state_reg != S_DONE) begin
                m_tvalid_reg <= 1'b0;
            end
            // the sigmoid's last step reloads the divider for the gradient
            if ((state_reg == S_DIVP && !div_done) || state_reg == S_DIVG ||
                state_reg == S_DIVM) begin
                dvd_reg <= {dvd_reg[61:0], 1'b0};
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg - 6'd1;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        x16_reg  <= {s_tdata, 8'd0};
                        last_reg <= s_tlast;
                        mode_reg <= loss_mode_reg;
                        n_reg    <= n_clamp;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    u_reg    <= prod[40:16];
                    // hinge and unused modes load the gradient division here
                    dvd_reg  <= h_dvd;
                    rem_reg  <= 35'd0;
                    quo_reg  <= 63'd0;
                    dsr_reg  <= {17'd0, n_reg};
                    cnt_reg  <= 6'd31;
                    term_reg <= h_term;
                    neg_reg  <= h_neg;
                    if (mode_reg inside {MODE_BCE_REAL, MODE_BCE_FAKE}) begin
                        state_reg <= S_EXP;
                    end else begin
                        state_reg <= S_DIVG;
                    end
                end
                S_EXP: begin
                    e_reg     <= e_val;
                    state_reg <= S_LN;
                end
                S_LN: begin
                    term_reg <= bterm;
                    dvd_reg  <= x16_reg[23] ? {e_reg[32:0], 30'd0} : {1'b1, 62'd0};
                    rem_reg  <= 35'd0;
                    quo_reg  <= 63'd0;
                    dsr_reg  <= {1'b0, 33'h1_0000_0000} + {1'b0, e_reg};
                    cnt_reg  <= 6'd63;
                    state_reg <= S_DIVP;
                end
                S_DIVP: begin
                    if (div_done) begin
                        dvd_reg <= {bce_mag, 32'd0};
                        rem_reg <= 35'd0;
                        quo_reg <= 63'd0;
                        dsr_reg <= {17'd0, n_reg};
                        cnt_reg <= 6'd31;
                        neg_reg <= (mode_reg == MODE_BCE_REAL);
                        state_reg <= S_DIVG;
                    end
                end
                S_DIVG: begin
                    if (div_done) begin
                        grad_reg  <= neg_reg ? (~{1'b0, quo_next[30:0]} + 32'd1)
                                             : {1'b0, quo_next[30:0]};
                        state_reg <= S_SUM;
                    end
                end
                S_SUM: begin
                    loss_sum_reg <= sum_sat;
                    mean_reg     <= 32'd0;
                    if (last_reg) begin
                        dvd_reg <= {sum_mag, 23'd0};
                        rem_reg <= 35'd0;
                        quo_reg <= 63'd0;
                        dsr_reg <= {17'd0, n_reg};
                        cnt_reg <= 6'd40;
                        neg_reg <= sum_sat[39];
                        state_reg <= S_DIVM;
                    end else begin
                        state_reg <= S_DONE;
                    end
                end
                S_DIVM: begin
                    if (div_done) begin
                        mean_reg     <= mean_sat;
                        loss_sum_reg <= 40'sd0;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_grad_reg   <= grad_reg;
                        m_mean_reg   <= mean_reg;
                        m_last_reg   <= last_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_mean_reg, m_grad_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_mean_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[63:32] == 32'd0))
        else $error("mean loss nonzero on a non-last result");

    a_sum_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && last_reg) |-> (loss_sum_reg == 40'sd0))
        else $error("loss sum not cleared after last element");

    a_divider_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIVP || state_reg == S_DIVG || state_reg == S_DIVM)
            |-> (cnt_reg != 6'd0))
        else $error("divider ran out of steps");
`endif

endmodule

`default_nettype wire
